>>> rtl/assert_macros.svh
// Assertion macros for the checker file rqc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define RQC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication under an active-low reset.
`define RQC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/rqc_pkg.sv
// Shared types and constants of the read QC statistics collector.
`timescale 1ns / 1ps
package rqc_pkg;

	localparam int MAX_READ_LEN_DEF = 256;
	localparam int MATES_DEF        = 2;
	localparam int POS_W            = 13;  // holds positions up to 4096
	localparam int QUEUE_DEPTH      = 4;
	localparam int NUM_CLASSES      = 5;
	localparam int GC_BINS          = 101;

	localparam logic [1:0] CFG_ENABLE     = 2'd0;
	localparam logic [1:0] CFG_MATE_COUNT = 2'd1;
	localparam logic [1:0] CFG_MAX_READS  = 2'd2;
	localparam logic [1:0] CFG_QUAL_BASE  = 2'd3;

	localparam logic [2:0] SEL_MATE_READS = 3'd0;
	localparam logic [2:0] SEL_LEN_HIST   = 3'd1;
	localparam logic [2:0] SEL_GC_HIST    = 3'd2;
	localparam logic [2:0] SEL_POS_COUNT  = 3'd3;
	localparam logic [2:0] SEL_QUAL_SUM   = 3'd4;
	localparam logic [2:0] SEL_BASE_COUNT = 3'd5;
	localparam logic [2:0] SEL_TOTAL      = 3'd6;

	localparam logic [2:0] CLS_C = 3'd1;
	localparam logic [2:0] CLS_G = 3'd2;
	localparam logic [2:0] CLS_N = 3'd4;

	// one queue entry: work for the back end
	typedef struct packed {
		logic             do_base;
		logic             do_end;
		logic             do_query;
		logic [1:0]       mate;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] len;
		logic [POS_W-1:0] gc;
		logic [2:0]       cls;
		logic [7:0]       phred;
		logic [2:0]       sel;
		logic [8:0]       idx;
		logic [2:0]       bsel;
	} cmd_t;

	// back end status seen by the front end
	typedef struct packed {
		logic        idle;
		logic        clearing;
		logic [47:0] total;
	} back_status_t;

endpackage

>>> rtl/rqc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rqc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/rqc_fifo.sv
// Short command queue between front and back end.
`timescale 1ns / 1ps
module rqc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rqc_pkg::cmd_t push_data,
	input  logic          pop,
	output rqc_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	localparam int D  = rqc_pkg::QUEUE_DEPTH;
	localparam int AW = $clog2(D);

	rqc_pkg::cmd_t entry_q [D];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (AW+1)'(D));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/rqc_front.sv
// Front end: config registers, read tracking and command classification.
`timescale 1ns / 1ps
module rqc_front #(
	parameter int MAX_READ_LEN = rqc_pkg::MAX_READ_LEN_DEF,
	parameter int MATES        = rqc_pkg::MATES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [1:0]            cfg_index,
	input  logic [47:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [1:0]            mate,
	input  logic [7:0]            base_code,
	input  logic [7:0]            quality_byte,
	input  logic                  last_base,
	input  logic [2:0]            table_select,
	input  logic [8:0]            table_index,
	input  logic [2:0]            base_select,
	input  rqc_pkg::back_status_t st,
	input  logic                  q_empty,
	input  logic                  q_full,
	output logic                  q_push,
	output rqc_pkg::cmd_t         q_data
);

	localparam int PW  = $clog2(MAX_READ_LEN + 1);
	localparam int PSW = rqc_pkg::POS_W;

	logic        en_q;
	logic [1:0]  mc_q;
	logic [47:0] max_q;
	logic [7:0]  qb_q;

	logic [PW-1:0] pos_q;
	logic [PW-1:0] gc_q;
	logic [1:0]    mate_q;
	logic          acc_q;

	logic          start, accept_read, acc, in_range, counted, is_gc, beat;
	logic [1:0]    mt;
	logic [PW-1:0] gc_cur, gc_nx, pos_nx;
	logic [2:0]    cls;
	logic [7:0]    phred;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			mc_q  <= 2'd1;
			max_q <= '0;
			qb_q  <= 8'd33;
		end else if (cfg_valid) begin
			case (cfg_index)
				rqc_pkg::CFG_ENABLE:     en_q  <= cfg_data[0];
				rqc_pkg::CFG_MATE_COUNT: mc_q  <= cfg_data[1:0];
				rqc_pkg::CFG_MAX_READS:  max_q <= cfg_data;
				rqc_pkg::CFG_QUAL_BASE:  qb_q  <= cfg_data[7:0];
				default:                 en_q  <= en_q;
			endcase
		end
	end

	assign start       = (pos_q == '0);
	assign accept_read = en_q && (mate < mc_q) && (32'(mate) < MATES)
		&& !((max_q != '0) && (st.total >= max_q));
	assign acc         = start ? accept_read : acc_q;
	assign mt          = start ? mate : mate_q;
	assign gc_cur      = start ? '0 : gc_q;
	assign in_range    = (pos_q < PW'(MAX_READ_LEN));
	assign counted     = acc && in_range;
	assign cls         = (base_code < 8'(rqc_pkg::NUM_CLASSES)) ? base_code[2:0]
		: rqc_pkg::CLS_N;
	assign is_gc       = (cls == rqc_pkg::CLS_C) || (cls == rqc_pkg::CLS_G);
	assign phred       = (quality_byte > qb_q) ? (quality_byte - qb_q) : 8'd0;
	assign gc_nx       = gc_cur + PW'(counted && is_gc);
	assign pos_nx      = in_range ? (pos_q + 1'b1) : pos_q;

	// a new read waits until every earlier command is done, so the
	// accepted-read total it checks is current
	assign in_ready = !q_full && !st.clearing && !(start && !(q_empty && st.idle));
	assign beat     = in_valid && in_ready;
	assign q_push   = beat && (operation || counted || (acc && last_base));

	always_comb begin
		q_data          = '0;
		q_data.do_query = operation;
		q_data.do_base  = !operation && counted;
		q_data.do_end   = !operation && acc && last_base;
		q_data.mate     = operation ? mate : mt;
		q_data.pos      = PSW'(pos_q);
		q_data.len      = PSW'(pos_nx);
		q_data.gc       = PSW'(gc_nx);
		q_data.cls      = cls;
		q_data.phred    = phred;
		q_data.sel      = table_select;
		q_data.idx      = table_index;
		q_data.bsel     = base_select;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			gc_q   <= '0;
			mate_q <= '0;
			acc_q  <= 1'b0;
		end else if (beat && !operation) begin
			if (last_base) begin
				pos_q  <= '0;
				gc_q   <= '0;
				mate_q <= '0;
				acc_q  <= 1'b0;
			end else begin
				pos_q  <= pos_nx;
				gc_q   <= gc_nx;
				mate_q <= mt;
				acc_q  <= acc;
			end
		end
	end

endmodule

>>> rtl/rqc_back.sv
// Back end: counter memories, read-modify-write, GC divider and queries.
`timescale 1ns / 1ps
module rqc_back #(
	parameter int MAX_READ_LEN = rqc_pkg::MAX_READ_LEN_DEF,
	parameter int MATES        = rqc_pkg::MATES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rqc_pkg::cmd_t         head,
	input  logic                  q_empty,
	output logic                  q_pop,
	output rqc_pkg::back_status_t st,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [47:0]           stat_value
);

	localparam int MW      = (MATES > 1) ? $clog2(MATES) : 1;
	localparam int PAW     = $clog2(MAX_READ_LEN);
	localparam int PW      = $clog2(MAX_READ_LEN + 1);
	localparam int POS_AW  = MW + PAW;
	localparam int BASE_AW = POS_AW + 3;
	localparam int LEN_AW  = MW + PW;
	localparam int GC_AW   = MW + 7;
	localparam int PSW     = rqc_pkg::POS_W;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_BWR   = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_EISS  = 7'b0010000,
		ST_EWR   = 7'b0100000,
		ST_QOUT  = 7'b1000000
	} state_t;

	state_t        state_q;
	rqc_pkg::cmd_t cmd_q;
	logic [BASE_AW-1:0] clr_q;
	logic [19:0]   rem_q;
	logic [6:0]    quo_q;
	logic [2:0]    step_q;
	logic [47:0]   total_q;
	logic [47:0]   mate_cnt_q [MATES];
	logic          out_valid_q;
	logic [47:0]   out_data_q;

	logic [MW-1:0]  m_h, m_c;
	logic [2:0]     mh3, mc3;
	logic [PSW-1:0] idx_ext, pos_sel;
	logic           head_go, clearing, out_free, div_init;
	logic [PSW-1:0] gc_src;
	logic [19:0]    den_sh;
	logic           trial_ok;
	logic [6:0]     quo_nx;
	logic [47:0]    qval;
	logic           mate_ok;

	logic              pos_we, pos_re, base_we, base_re, len_we, len_re, gc_we, gc_re;
	logic [POS_AW-1:0] pos_wa, pos_ra;
	logic [BASE_AW-1:0] base_wa, base_ra;
	logic [LEN_AW-1:0] len_wa, len_ra;
	logic [GC_AW-1:0]  gc_wa, gc_ra;
	logic [79:0]       pos_wd, pos_rd;
	logic [31:0]       base_wd, base_rd, len_wd, len_rd, gc_wd, gc_rd;
	logic [48:0]       qsum_add;

	assign mh3      = {1'b0, head.mate};
	assign mc3      = {1'b0, cmd_q.mate};
	assign m_h      = mh3[MW-1:0];
	assign m_c      = mc3[MW-1:0];
	assign idx_ext  = PSW'(head.idx);
	assign pos_sel  = head.do_query ? idx_ext : head.pos;
	assign clearing = (state_q == ST_CLEAR);
	assign head_go  = (state_q == ST_IDLE) && !q_empty;
	assign q_pop    = head_go;
	assign out_free = !out_valid_q || out_ready;

	// read side
	assign pos_re  = head_go;
	assign base_re = head_go;
	assign len_re  = head_go || (state_q == ST_EISS);
	assign gc_re   = head_go || (state_q == ST_EISS);
	assign pos_ra  = {m_h, pos_sel[PAW-1:0]};
	assign base_ra = {m_h, pos_sel[PAW-1:0], head.do_query ? head.bsel : head.cls};
	assign len_ra  = (state_q == ST_EISS) ? {m_c, cmd_q.len[PW-1:0]}
		: {m_h, idx_ext[PW-1:0]};
	assign gc_ra   = (state_q == ST_EISS) ? {m_c, quo_q} : {m_h, head.idx[6:0]};

	// write side: clearing pass or read-modify-write
	assign qsum_add = {1'b0, pos_rd[79:32]} + 49'(cmd_q.phred);
	assign pos_we   = clearing || (state_q == ST_BWR);
	assign base_we  = clearing || (state_q == ST_BWR);
	assign len_we   = clearing || (state_q == ST_EWR);
	assign gc_we    = clearing || (state_q == ST_EWR);
	assign pos_wa   = clearing ? clr_q[POS_AW-1:0] : {m_c, cmd_q.pos[PAW-1:0]};
	assign base_wa  = clearing ? clr_q : {m_c, cmd_q.pos[PAW-1:0], cmd_q.cls};
	assign len_wa   = clearing ? clr_q[LEN_AW-1:0] : {m_c, cmd_q.len[PW-1:0]};
	assign gc_wa    = clearing ? clr_q[GC_AW-1:0] : {m_c, quo_q};
	assign pos_wd   = clearing ? '0 : {
		qsum_add[48] ? {48{1'b1}} : qsum_add[47:0],
		(&pos_rd[31:0]) ? pos_rd[31:0] : pos_rd[31:0] + 1'b1};
	assign base_wd  = clearing ? '0 : ((&base_rd) ? base_rd : base_rd + 1'b1);
	assign len_wd   = clearing ? '0 : ((&len_rd) ? len_rd : len_rd + 1'b1);
	assign gc_wd    = clearing ? '0 : ((&gc_rd) ? gc_rd : gc_rd + 1'b1);

	rqc_ram #(.WIDTH(80), .DEPTH(2**POS_AW)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd),
		.re(pos_re), .raddr(pos_ra), .rdata(pos_rd));

	rqc_ram #(.WIDTH(32), .DEPTH(2**BASE_AW)) u_base_ram (
		.clk(clk), .we(base_we), .waddr(base_wa), .wdata(base_wd),
		.re(base_re), .raddr(base_ra), .rdata(base_rd));

	rqc_ram #(.WIDTH(32), .DEPTH(2**LEN_AW)) u_len_ram (
		.clk(clk), .we(len_we), .waddr(len_wa), .wdata(len_wd),
		.re(len_re), .raddr(len_ra), .rdata(len_rd));

	rqc_ram #(.WIDTH(32), .DEPTH(2**GC_AW)) u_gc_ram (
		.clk(clk), .we(gc_we), .waddr(gc_wa), .wdata(gc_wd),
		.re(gc_re), .raddr(gc_ra), .rdata(gc_rd));

	// GC percent: restoring division, one quotient bit per cycle
	assign div_init = ((state_q == ST_IDLE) && head_go && !head.do_query && !head.do_base)
		|| ((state_q == ST_BWR) && cmd_q.do_end);
	assign gc_src   = (state_q == ST_IDLE) ? head.gc : cmd_q.gc;
	assign den_sh   = 20'(cmd_q.len) << step_q;
	assign trial_ok = (rem_q >= den_sh);
	always_comb begin
		quo_nx = quo_q;
		quo_nx[step_q] = trial_ok;
	end

	// query result
	assign mate_ok = (32'(cmd_q.mate) < MATES);
	always_comb begin
		qval = '0;
		if (cmd_q.sel == rqc_pkg::SEL_TOTAL) begin
			qval = total_q;
		end else if (mate_ok) begin
			case (cmd_q.sel)
				rqc_pkg::SEL_MATE_READS: qval = mate_cnt_q[m_c];
				rqc_pkg::SEL_LEN_HIST:
					qval = (32'(cmd_q.idx) <= MAX_READ_LEN) ? 48'(len_rd) : '0;
				rqc_pkg::SEL_GC_HIST:
					qval = (32'(cmd_q.idx) < rqc_pkg::GC_BINS) ? 48'(gc_rd) : '0;
				rqc_pkg::SEL_POS_COUNT:
					qval = (32'(cmd_q.idx) < MAX_READ_LEN) ? 48'(pos_rd[31:0]) : '0;
				rqc_pkg::SEL_QUAL_SUM:
					qval = (32'(cmd_q.idx) < MAX_READ_LEN) ? pos_rd[79:32] : '0;
				rqc_pkg::SEL_BASE_COUNT:
					qval = ((32'(cmd_q.idx) < MAX_READ_LEN)
						&& (32'(cmd_q.bsel) < rqc_pkg::NUM_CLASSES)) ? 48'(base_rd) : '0;
				default: qval = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (head_go) begin
			cmd_q <= head;
		end
		if (div_init) begin
			rem_q  <= (20'(gc_src) << 6) + (20'(gc_src) << 5) + (20'(gc_src) << 2);
			quo_q  <= '0;
			step_q <= 3'd6;
		end else if (state_q == ST_DIV) begin
			if (trial_ok) begin
				rem_q <= rem_q - den_sh;
			end
			quo_q  <= quo_nx;
			step_q <= step_q - 1'b1;
		end
		if ((state_q == ST_QOUT) && out_free) begin
			out_data_q <= qval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MATES; i++) begin
				mate_cnt_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head_go) begin
						if (head.do_query) begin
							state_q <= ST_QOUT;
						end else if (head.do_base) begin
							state_q <= ST_BWR;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_BWR: begin
					state_q <= cmd_q.do_end ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_EISS;
					end
				end
				ST_EISS: begin
					state_q <= ST_EWR;
				end
				ST_EWR: begin
					if (!(&mate_cnt_q[m_c])) begin
						mate_cnt_q[m_c] <= mate_cnt_q[m_c] + 1'b1;
					end
					if (!(&total_q)) begin
						total_q <= total_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_QOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign st.idle     = (state_q == ST_IDLE);
	assign st.clearing = clearing;
	assign st.total    = total_q;
	assign out_valid   = out_valid_q;
	assign stat_value  = out_data_q;

endmodule

>>> rtl/read_qc_statistics_collector_unit.sv
// Top level of the read QC statistics collector.
`timescale 1ns / 1ps
// Collects per-mate read QC statistics from a stream of bases, one base per
// beat with tlast on the last base of a read, and answers query beats
// (tuser = 1) with one 48-bit counter value on the master side. A front end
// takes beats into a 4-entry command queue at up to one per cycle; a back end
// does the counter updates as read-modify-write on registered-read RAMs.
// Back end steps per beat: a counted base is dispatched, then written back
// (ST_BWR); the last base of an accepted read then runs the bit-serial GC
// percent divider and the histogram update (ST_EISS, ST_EWR); a query is
// dispatched, then offered (ST_QOUT) after any wait on m_axis_tready. Bases
// of dropped reads cost nothing in the back end, nor do bases past MAX_READ_LEN
// except the last of an accepted read: dispatched, divider, histogram update.
// The first base of each read is held until the queue and back end have
// drained, since the accept decision needs the final accepted-read total.
// After reset the counter RAMs are zeroed by a clearing pass over
// 8 * MATES_P2 * 2**clog2(MAX_READ_LEN) addresses (4096 with defaults, MATES_P2
// being MATES rounded up to a power of two, at least 2); s_axis_tready stays
// low during it, while config writes are taken at once (cfg_ready is tied high).
module read_qc_statistics_collector_unit #(
	parameter int MAX_READ_LEN = rqc_pkg::MAX_READ_LEN_DEF,
	parameter int MATES        = rqc_pkg::MATES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write: index 0 enable, 1 mate_count, 2 max_reads, 3 quality_base
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	// input beats
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mate[1:0], base_code[9:2], quality_byte[17:10], table_select[20:18],
	// table_index[29:21], base_select[32:30], zero pad [39:33]
	input  logic [39:0] s_axis_tdata,
	// operation: 0 base, 1 query
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,   // last_base
	// result beats
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// stat_value[47:0]
	output logic [47:0] m_axis_tdata
);

	rqc_pkg::cmd_t         q_in, q_head;
	rqc_pkg::back_status_t st;
	logic                  q_push, q_pop, q_empty, q_full;

	assign cfg_ready = 1'b1;

	rqc_front #(.MAX_READ_LEN(MAX_READ_LEN), .MATES(MATES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.operation    (s_axis_tuser),
		.mate         (s_axis_tdata[1:0]),
		.base_code    (s_axis_tdata[9:2]),
		.quality_byte (s_axis_tdata[17:10]),
		.last_base    (s_axis_tlast),
		.table_select (s_axis_tdata[20:18]),
		.table_index  (s_axis_tdata[29:21]),
		.base_select  (s_axis_tdata[32:30]),
		.st           (st),
		.q_empty      (q_empty),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_in)
	);

	rqc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	rqc_back #(.MAX_READ_LEN(MAX_READ_LEN), .MATES(MATES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.st         (st),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.stat_value (m_axis_tdata)
	);

endmodule

>>> rtl/rqc_checker.sv
// Port-level checks for the read QC statistics collector, bound to the top.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rqc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	// a stalled result beat stays offered unchanged
	`RQC_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	// clearing pass: no input taken and no result right after reset
	`RQC_ASSERT_IMP(a_clear_first, clk, arst_n, !$past(arst_n), !s_axis_tready && !m_axis_tvalid)
	`RQC_ASSERT_IMP(a_clear_second, clk, arst_n, !$past(arst_n, 2), !s_axis_tready && !m_axis_tvalid)

endmodule

bind read_qc_statistics_collector_unit rqc_checker u_rqc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
